FILE: design/inverse_distance_interpolator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the inverse distance interpolator
// Short forms for same-cycle and next-cycle implications on clk.
// ----------------------------------------------------------------------------
`ifndef INVERSE_DISTANCE_INTERPOLATOR_TOP_MACROS_SVH
`define INVERSE_DISTANCE_INTERPOLATOR_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define IDI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define IDI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/idi_pkg.sv
// ----------------------------------------------------------------------------
// idi_pkg
// Shared constants, codes and types of the inverse distance interpolator.
// ----------------------------------------------------------------------------
package idi_pkg;

	// Default data and accumulator widths.
	localparam int DATA_WIDTH_DEF = 32;
	localparam int ACC_WIDTH_DEF  = 64;

	// Configuration register fields.
	localparam int POW_W     = 4;
	localparam int MPD_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [POW_W-1:0] POW_RESET = 4'd2;
	localparam logic [POW_W-1:0] POW_MIN   = 4'd1;
	localparam logic [POW_W-1:0] POW_MAX   = 4'd8;
	localparam logic [MPD_W-1:0] MPD_RESET = 16'd1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_POWER       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWERED_DISTANCE = 2'd1;

	// Powered distance cap, 1.0 in Q16.16 squared terms.
	localparam int PCAP_W = 33;
	localparam logic [PCAP_W-1:0] PCAP = 33'h1_0000_0000;

	// Effective configuration handed to the engine.
	typedef struct packed {
		logic [POW_W-1:0] pow;
		logic [MPD_W-1:0] mpd;
	} cfg_t;

	// Engine status seen by the top level.
	typedef struct packed {
		logic busy;
		logic wsum_zero;
	} back_stat_t;

	// Engine sequencer states.
	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_SQ   = 10'b00_0000_0010,
		ST_SQRT = 10'b00_0000_0100,
		ST_POW  = 10'b00_0000_1000,
		ST_DIVW = 10'b00_0001_0000,
		ST_MUL  = 10'b00_0010_0000,
		ST_ACC  = 10'b00_0100_0000,
		ST_QST  = 10'b00_1000_0000,
		ST_QDIV = 10'b01_0000_0000,
		ST_QOUT = 10'b10_0000_0000
	} back_state_t;

endpackage

FILE: design/inverse_distance_interpolator_top.sv
// ----------------------------------------------------------------------------
// inverse_distance_interpolator_top
// Shepard inverse distance interpolation over a stream of neighbor beats.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one neighbor center, its value and the
// query point; last_neighbor closes the set. One output beat per set gives
// the weighted mean value, saturated to the data range.
// Configuration beats (cfg_index, cfg_data) set the distance power and the
// minimum powered distance; write them only while the block is idle.
// Sequence: a neighbor beat passes through the idle state, the squares, the
// square root, the power steps, the reciprocal divide and the
// multiply/accumulate steps. A last neighbor beat adds the final divide.
// Both divides use the shared divider. A two-entry input queue lets the
// next beats arrive while the engine works.
// Reset clears the accumulators and sets power 2, minimum distance 1.
// When the receiver stalls, the result waits in the output register; the
// engine keeps working on further non-final beats meanwhile.
// ----------------------------------------------------------------------------
module inverse_distance_interpolator_top #(
	parameter int DATA_WIDTH = idi_pkg::DATA_WIDTH_DEF,
	parameter int ACC_WIDTH  = idi_pkg::ACC_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [idi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [idi_pkg::MPD_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [DATA_WIDTH-1:0]    neighbor_x,
	input  logic signed [DATA_WIDTH-1:0]    neighbor_y,
	input  logic signed [DATA_WIDTH-1:0]    neighbor_z,
	input  logic signed [DATA_WIDTH-1:0]    neighbor_value,
	input  logic signed [DATA_WIDTH-1:0]    query_x,
	input  logic signed [DATA_WIDTH-1:0]    query_y,
	input  logic signed [DATA_WIDTH-1:0]    query_z,
	input  logic                            last_neighbor,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [DATA_WIDTH-1:0]    interpolated_value
);
	import idi_pkg::*;

	`include "inverse_distance_interpolator_top_macros.svh"

	logic [POW_W-1:0]      pow_q;
	logic [MPD_W-1:0]      mpd_q;
	cfg_t                  cfg;
	logic                  q_valid, q_pop, q_last;
	logic [DATA_WIDTH:0]   q_mag_x, q_mag_y, q_mag_z;
	logic [DATA_WIDTH-1:0] q_value;
	back_stat_t            stat;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pow_q <= POW_RESET;
			mpd_q <= MPD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DISTANCE_POWER:       pow_q <= cfg_data[POW_W-1:0];
				CFG_MIN_POWERED_DISTANCE: mpd_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Effective settings: power held to 1..8, clamp never zero.
	always_comb begin
		cfg.pow = pow_q;
		if (pow_q < POW_MIN) begin
			cfg.pow = POW_MIN;
		end else if (pow_q > POW_MAX) begin
			cfg.pow = POW_MAX;
		end
		cfg.mpd = (mpd_q == '0) ? MPD_W'(1) : mpd_q;
	end

	idi_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.neighbor_x     (neighbor_x),
		.neighbor_y     (neighbor_y),
		.neighbor_z     (neighbor_z),
		.neighbor_value (neighbor_value),
		.query_x        (query_x),
		.query_y        (query_y),
		.query_z        (query_z),
		.last_neighbor  (last_neighbor),
		.q_valid        (q_valid),
		.q_pop          (q_pop),
		.q_mag_x        (q_mag_x),
		.q_mag_y        (q_mag_y),
		.q_mag_z        (q_mag_z),
		.q_value        (q_value),
		.q_last         (q_last)
	);

	idi_back #(.DATA_WIDTH(DATA_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.q_valid            (q_valid),
		.q_pop              (q_pop),
		.q_mag_x            (q_mag_x),
		.q_mag_y            (q_mag_y),
		.q_mag_z            (q_mag_z),
		.q_value            (q_value),
		.q_last             (q_last),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.interpolated_value (interpolated_value),
		.stat               (stat)
	);

	// The engine only takes a queued beat when it is free.
	`IDI_ASSERT_NOW(a_pop_when_free, q_pop, q_valid && !stat.busy, "pop while busy or empty")
	// A new result always follows at least one accumulated weight.
	`IDI_ASSERT_NOW(a_result_has_weight, $rose(out_valid), $past(!stat.wsum_zero), "result with zero weight sum")
	// A stalled result holds its value.
	`IDI_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(interpolated_value), "stalled result changed")
endmodule

FILE: design/idi_div.sv
// ----------------------------------------------------------------------------
// idi_div
// Restoring unsigned divider, W-bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module idi_div #(
	parameter int W = idi_pkg::ACC_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W:0]    rem_q;
	logic [W:0]    rem_sh;
	logic          fits;

	// Shift in the next dividend bit and try the subtraction.
	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	// Control: count off the W quotient bits, pulse done at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

FILE: design/idi_front.sv
// ----------------------------------------------------------------------------
// idi_front
// Input side: takes beats, forms axis distance magnitudes, two-entry queue.
// ----------------------------------------------------------------------------
module idi_front #(
	parameter int DATA_WIDTH = idi_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] neighbor_x,
	input  logic signed [DATA_WIDTH-1:0] neighbor_y,
	input  logic signed [DATA_WIDTH-1:0] neighbor_z,
	input  logic signed [DATA_WIDTH-1:0] neighbor_value,
	input  logic signed [DATA_WIDTH-1:0] query_x,
	input  logic signed [DATA_WIDTH-1:0] query_y,
	input  logic signed [DATA_WIDTH-1:0] query_z,
	input  logic                         last_neighbor,
	output logic                         q_valid,
	input  logic                         q_pop,
	output logic [DATA_WIDTH:0]          q_mag_x,
	output logic [DATA_WIDTH:0]          q_mag_y,
	output logic [DATA_WIDTH:0]          q_mag_z,
	output logic signed [DATA_WIDTH-1:0] q_value,
	output logic                         q_last
);
	localparam int DW = DATA_WIDTH;

	logic signed [DW:0] dx, dy, dz;
	logic [DW:0]        mx, my, mz;
	logic [DW:0]        mag_x_q [2];
	logic [DW:0]        mag_y_q [2];
	logic [DW:0]        mag_z_q [2];
	logic [DW-1:0]      val_q   [2];
	logic [1:0]         last_q;
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;

	// Exact differences and their magnitudes.
	assign dx = {neighbor_x[DW-1], neighbor_x} - {query_x[DW-1], query_x};
	assign dy = {neighbor_y[DW-1], neighbor_y} - {query_y[DW-1], query_y};
	assign dz = {neighbor_z[DW-1], neighbor_z} - {query_z[DW-1], query_z};
	assign mx = dx[DW] ? -dx : dx;
	assign my = dy[DW] ? -dy : dy;
	assign mz = dz[DW] ? -dz : dz;

	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != 2'd0;

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mag_x_q[wr_ptr_q] <= mx;
			mag_y_q[wr_ptr_q] <= my;
			mag_z_q[wr_ptr_q] <= mz;
			val_q[wr_ptr_q]   <= neighbor_value;
			last_q[wr_ptr_q]  <= last_neighbor;
		end
	end

	assign q_mag_x = mag_x_q[rd_ptr_q];
	assign q_mag_y = mag_y_q[rd_ptr_q];
	assign q_mag_z = mag_z_q[rd_ptr_q];
	assign q_value = val_q[rd_ptr_q];
	assign q_last  = last_q[rd_ptr_q];
endmodule

FILE: design/idi_back.sv
// ----------------------------------------------------------------------------
// idi_back
// Engine: squares, root, power, reciprocal weight, accumulate and result.
// ----------------------------------------------------------------------------
module idi_back #(
	parameter int DATA_WIDTH = idi_pkg::DATA_WIDTH_DEF,
	parameter int ACC_WIDTH  = idi_pkg::ACC_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  idi_pkg::cfg_t                cfg,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  logic [DATA_WIDTH:0]          q_mag_x,
	input  logic [DATA_WIDTH:0]          q_mag_y,
	input  logic [DATA_WIDTH:0]          q_mag_z,
	input  logic signed [DATA_WIDTH-1:0] q_value,
	input  logic                         q_last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] interpolated_value,
	output idi_pkg::back_stat_t          stat
);
	import idi_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int AW = ACC_WIDTH;
	localparam logic [AW-1:0] ASMAX  = {1'b0, {(AW-1){1'b1}}};
	localparam logic [AW-1:0] ASMIN  = {1'b1, {(AW-1){1'b0}}};
	localparam logic [95:0]   LIM_P  = (96'd1 << (AW - 1)) - 96'd1;
	localparam logic [95:0]   LIM_N  = 96'd1 << (AW - 1);
	localparam logic [AW-1:0] QNMAX  = AW'(1) << (DW - 1);
	localparam logic [AW-1:0] QPMAX  = (AW'(1) << (DW - 1)) - AW'(1);

	back_state_t       state_q;
	logic [5:0]        cnt_q;
	logic [DW:0]       mag_q [3];
	logic [DW-1:0]     val_q;
	logic              last_q;
	logic [63:0]       s2_q, x_q;
	logic [33:0]       rem_q;
	logic [31:0]       root_q;
	logic [32:0]       p_q, w_q;
	logic [63:0]       pl_q, ph_q;
	logic [AW-1:0]     term_q, wvs_q, wsum_q;
	logic              wneg_q;
	logic [DW-1:0]     res_q;
	logic              res_valid_q;

	logic [DW:0]       mag_sel;
	logic [63:0]       mag64, m64, sq, s2_d;
	logic [64:0]       s2_sum;
	logic [31:0]       mul_a, mul_b;
	logic [63:0]       prod;
	logic [33:0]       rem_sh, trial;
	logic              take;
	logic [33:0]       rem_d;
	logic [31:0]       root_d;
	logic [47:0]       pw_t;
	logic [32:0]       pw_d, pc;
	logic [DW-1:0]     vmag;
	logic              vneg;
	logic [95:0]       prod96, pm;
	logic [AW:0]       acc_s, ws_s;
	logic [AW-1:0]     wvs_d, wsum_d, wvs_mag;
	logic              div_start, div_done;
	logic [AW-1:0]     div_a, div_b, div_q, qv, qs;
	logic [DW-1:0]     res_d;
	logic              out_free;
	logic              res_load;

	// Axis magnitude for the square in progress.
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    mag_sel = mag_q[0];
			2'd1:    mag_sel = mag_q[1];
			default: mag_sel = mag_q[2];
		endcase
	end
	assign mag64 = 64'(mag_sel);

	// Value magnitude, split over two multiplier passes.
	assign vneg = val_q[DW-1];
	assign vmag = vneg ? -val_q : val_q;
	assign m64  = 64'(vmag);

	// Shared 32x32 multiplier.
	always_comb begin
		case (state_q)
			ST_SQ: begin
				mul_a = mag64[31:0];
				mul_b = mag64[31:0];
			end
			ST_POW: begin
				mul_a = p_q[31:0];
				mul_b = root_q;
			end
			ST_MUL: begin
				mul_a = (cnt_q == 6'd0) ? m64[31:0] : m64[63:32];
				mul_b = w_q[31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// Saturating sum of squares.
	assign sq     = (|mag64[63:32]) ? '1 : prod;
	assign s2_sum = {1'b0, s2_q} + {1'b0, sq};
	assign s2_d   = s2_sum[64] ? '1 : s2_sum[63:0];

	// One digit of the square root.
	assign rem_sh = {rem_q[31:0], x_q[63:62]};
	assign trial  = {root_q, 2'b01};
	assign take   = rem_sh >= trial;
	assign rem_d  = take ? (rem_sh - trial) : rem_sh;
	assign root_d = {root_q[30:0], take};

	// One power step, capped at one in Q0.32 terms.
	assign pw_t = prod[63:16];
	assign pw_d = (pw_t > 48'(PCAP)) ? PCAP : pw_t[32:0];
	assign pc   = (p_q < 33'(cfg.mpd)) ? 33'(cfg.mpd) : p_q;

	// Weighted value magnitude, saturated to the accumulator range.
	assign prod96 = w_q[32] ? {m64, 32'd0} : ({32'd0, pl_q} + {ph_q, 32'd0});
	always_comb begin
		if (vneg) begin
			pm = (prod96 > LIM_N) ? LIM_N : prod96;
		end else begin
			pm = (prod96 > LIM_P) ? LIM_P : prod96;
		end
	end

	// Saturating accumulators.
	assign acc_s  = {wvs_q[AW-1], wvs_q} + {term_q[AW-1], term_q};
	assign wvs_d  = (acc_s[AW] != acc_s[AW-1]) ? (acc_s[AW] ? ASMIN : ASMAX)
		: acc_s[AW-1:0];
	assign ws_s   = {1'b0, wsum_q} + (AW + 1)'(w_q);
	assign wsum_d = ws_s[AW] ? '1 : ws_s[AW-1:0];
	assign wvs_mag = wvs_q[AW-1] ? -wvs_q : wvs_q;

	// Divider operands: reciprocal weight, then the final quotient.
	assign div_start = ((state_q == ST_POW) && (cnt_q >= 6'(cfg.pow)))
		|| (state_q == ST_QST);
	assign div_a = (state_q == ST_QST) ? wvs_mag : AW'(PCAP);
	assign div_b = (state_q == ST_QST) ? wsum_q : AW'(pc);

	idi_div #(.W(AW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	// Final quotient saturated to the data range.
	assign qv = (wsum_q == '0) ? '0 : div_q;
	always_comb begin
		if (wneg_q) begin
			qs    = (qv > QNMAX) ? QNMAX : qv;
			res_d = DW'(-qs);
		end else begin
			qs    = (qv > QPMAX) ? QPMAX : qv;
			res_d = qs[DW-1:0];
		end
	end

	assign out_free = !res_valid_q || out_ready;
	assign res_load = (state_q == ST_QOUT) && out_free;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			wvs_q       <= '0;
			wsum_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// Output register: load a new result or drop the accepted one.
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cnt_q   <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (cnt_q == 6'd2) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == 6'd31) begin
						cnt_q   <= 6'd1;
						state_q <= ST_POW;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_POW: begin
					cnt_q <= cnt_q + 6'd1;
					if (div_start) begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd2) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					wvs_q   <= wvs_d;
					wsum_q  <= wsum_d;
					state_q <= last_q ? ST_QST : ST_IDLE;
				end
				ST_QST: begin
					state_q <= ST_QDIV;
				end
				ST_QDIV: begin
					if (div_done) begin
						state_q <= ST_QOUT;
					end
				end
				ST_QOUT: begin
					if (out_free) begin
						wvs_q   <= '0;
						wsum_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					mag_q[0] <= q_mag_x;
					mag_q[1] <= q_mag_y;
					mag_q[2] <= q_mag_z;
					val_q    <= q_value;
					last_q   <= q_last;
					s2_q     <= '0;
				end
			end
			ST_SQ: begin
				s2_q  <= s2_d;
				x_q   <= s2_d;
				rem_q <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= rem_d;
				root_q <= root_d;
				x_q    <= {x_q[61:0], 2'b00};
				if (cnt_q == 6'd31) begin
					p_q <= {1'b0, root_d};
				end
			end
			ST_POW: begin
				if (!div_start && !p_q[32]) begin
					p_q <= pw_d;
				end
			end
			ST_DIVW: begin
				if (div_done) begin
					w_q <= div_q[32:0];
				end
			end
			ST_MUL: begin
				if (cnt_q == 6'd0) begin
					pl_q <= prod;
				end else if (cnt_q == 6'd1) begin
					ph_q <= prod;
				end else begin
					term_q <= vneg ? -pm[AW-1:0] : pm[AW-1:0];
				end
			end
			ST_QST: begin
				wneg_q <= wvs_q[AW-1];
			end
			ST_QOUT: begin
				if (out_free) begin
					res_q <= res_d;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid          = res_valid_q;
	assign interpolated_value = res_q;
	assign stat.busy          = state_q != ST_IDLE;
	assign stat.wsum_zero     = wsum_q == '0;
endmodule
